### design/hav_pkg.sv
// package: constants and tables for the haversine distance pipeline
`timescale 1ns / 1ps
package hav_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int ROOT_STEPS = 32;

	localparam int S_TDATA_W = 128;
	localparam int M_TDATA_W = 32;
	localparam int RADIUS_W = 16;

	localparam logic [15:0] RADIUS_RESET = 16'd6371;

	localparam logic [31:0] DEG90_Q23 = 32'd754974720;
	localparam logic [31:0] DEG180_Q23 = 32'd1509949440;
	localparam logic [31:0] DEG360_Q23 = 32'd3019898880;
	localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	localparam logic [30:0] ATAN_Q30 [32] = '{
		31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
		31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
		31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
		31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
		31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
	};

	typedef logic [M_TDATA_W-1:0] dist_t;

endpackage

### design/haversine_distance.sv
// top level: pipelined haversine great-circle distance
`timescale 1ns / 1ps
//  channel  | dir | signals                               | payload
//  ---------+-----+---------------------------------------+------------------------------
//  s        | in  | s_tvalid, s_tready, s_tdata[127:0]    | lat_a, lon_a, lat_b, lon_b
//  m        | out | m_tvalid, m_tready, m_tdata[31:0]     | arc_distance
//  cfg      | in  | cfg_we, cfg_wdata[15:0]               | sphere_radius
//
//  one item per cycle while m is not stalled; the pipeline depth is set by the two cordic chains
//  and the 32-step square root chain
//  arst_n clears all valid bits and sets the radius to 6371
//  a stall on m freezes the pipeline in the cycle after it; the skid register holds the
//  item that was in flight, s_tready comes from that register alone
module haversine_distance
	import hav_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// lat_a[29:0], lon_a[60:30], lat_b[90:61], lon_b[121:91], zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// arc_distance[31:0]
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic [RADIUS_W-1:0]  cfg_wdata
);

	localparam int N = CORDIC_STAGES;
	localparam int IDX_SQ = 4 + N;
	localparam int IDX_ROOT = 7 + N;
	localparam int L = 40 + 2 * N;

	function automatic logic [30:0] clamp_q30(input logic signed [33:0] v);
		logic [30:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > 34'(ONE_Q30)) begin
			r = ONE_Q30;
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

	logic en;
	logic [L-1:0] vld_s;
	logic [RADIUS_W-1:0] radius_q;

	logic out_vld_q, skid_vld_q;
	dist_t out_dat_q, skid_dat_q, res_dat;

	assign en = !skid_vld_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[L-2:0], s_tvalid};
		end
	end

	// input and angle stages
	logic signed [29:0] lat_a_s1, lat_b_s1;
	logic signed [30:0] lon_a_s1, lon_b_s1;
	logic signed [31:0] ang_s2 [4];
	logic [29:0] m_s3 [4];
	logic neg_s3 [4];
	logic signed [32:0] z_s4 [4];
	logic neg_s4 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			lat_a_s1 <= s_tdata[29:0];
			lon_a_s1 <= s_tdata[60:30];
			lat_b_s1 <= s_tdata[90:61];
			lon_b_s1 <= s_tdata[121:91];
			ang_s2[0] <= 32'(lat_b_s1) - 32'(lat_a_s1);
			ang_s2[1] <= 32'(lon_b_s1) - 32'(lon_a_s1);
			ang_s2[2] <= 32'(lat_a_s1) <<< 1;
			ang_s2[3] <= 32'(lat_b_s1) <<< 1;
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_fold
		logic [31:0] mag, m1, m2;
		logic [56:0] zp;
		logic cneg;
		always_comb begin
			mag = ang_s2[c][31] ? 32'(-ang_s2[c]) : 32'(ang_s2[c]);
			m1 = (mag >= DEG180_Q23) ? DEG360_Q23 - mag : mag;
			cneg = m1 > DEG90_Q23;
			m2 = cneg ? DEG180_Q23 - m1 : m1;
			zp = 57'(m_s3[c]) * 57'(DEG_TO_RAD_Q32) + 57'(1 << 24);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				m_s3[c] <= m2[29:0];
				neg_s3[c] <= cneg;
				z_s4[c] <= signed'(33'(zp >> 25));
				neg_s4[c] <= neg_s3[c];
			end
		end
	end

	// rotation cordic, four lanes
	logic signed [33:0] rot_x_s [N][4];
	logic signed [33:0] rot_y_s [N][4];
	logic signed [32:0] rot_z_s [N][4];
	logic rot_n_s [N][4];

	for (genvar j = 0; j < N; j++) begin : g_rot
		logic signed [33:0] xi [4];
		logic signed [33:0] yi [4];
		logic signed [32:0] zi [4];
		logic ni [4];
		for (genvar c = 0; c < 4; c++) begin : g_lane
			if (j == 0) begin : g_first
				assign xi[c] = CORDIC_GAIN_Q30;
				assign yi[c] = '0;
				assign zi[c] = z_s4[c];
				assign ni[c] = neg_s4[c];
			end else begin : g_next
				assign xi[c] = rot_x_s[j-1][c];
				assign yi[c] = rot_y_s[j-1][c];
				assign zi[c] = rot_z_s[j-1][c];
				assign ni[c] = rot_n_s[j-1][c];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rot_n_s[j][c] <= ni[c];
					if (!zi[c][32]) begin
						rot_x_s[j][c] <= xi[c] - (yi[c] >>> j);
						rot_y_s[j][c] <= yi[c] + (xi[c] >>> j);
						rot_z_s[j][c] <= zi[c] - signed'(33'(ATAN_Q30[j]));
					end else begin
						rot_x_s[j][c] <= xi[c] + (yi[c] >>> j);
						rot_y_s[j][c] <= yi[c] - (xi[c] >>> j);
						rot_z_s[j][c] <= zi[c] + signed'(33'(ATAN_Q30[j]));
					end
				end
			end
		end
	end

	// squares, cosine product, weighted sum
	logic [30:0] s1, s2, cxa, cxb;
	logic signed [31:0] ca, cb;
	logic signed [63:0] pcc, pm;
	logic [61:0] p1, p2;
	logic [30:0] s1sq_s, s2sq_s;
	logic signed [31:0] cc_s;
	logic signed [32:0] sum_s;
	logic [30:0] h_s;
	logic signed [32:0] hsum;

	always_comb begin
		s1 = clamp_q30(rot_y_s[N-1][0]);
		s2 = clamp_q30(rot_y_s[N-1][1]);
		cxa = clamp_q30(rot_x_s[N-1][2]);
		cxb = clamp_q30(rot_x_s[N-1][3]);
		ca = rot_n_s[N-1][2] ? -signed'(32'(cxa)) : signed'(32'(cxa));
		cb = rot_n_s[N-1][3] ? -signed'(32'(cxb)) : signed'(32'(cxb));
		p1 = 62'(s1) * 62'(s1);
		p2 = 62'(s2) * 62'(s2);
		pcc = 64'(ca) * 64'(cb);
		pm = 64'(cc_s) * 64'(signed'({1'b0, s2sq_s}));
		hsum = sum_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1sq_s <= 31'(p1 >> 30);
			s2sq_s <= 31'(p2 >> 30);
			cc_s <= 32'(pcc >>> 30);
			sum_s <= 33'(pm >>> 30) + signed'({2'b00, s1sq_s});
			if (hsum < 0) begin
				h_s <= '0;
			end else if (hsum > 33'(ONE_Q30)) begin
				h_s <= ONE_Q30;
			end else begin
				h_s <= hsum[30:0];
			end
		end
	end

	// bitwise square roots of h and 1-h, one step per stage
	logic [63:0] rt_n_s [ROOT_STEPS][2];
	logic [63:0] rt_r_s [ROOT_STEPS][2];

	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
		localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
		logic [63:0] ni [2];
		logic [63:0] ri [2];
		for (genvar c = 0; c < 2; c++) begin : g_lane
			logic [63:0] t;
			if (i == 0) begin : g_first
				if (c == 0) begin : g_sin
					assign ni[c] = {3'b000, h_s, 30'd0};
				end else begin : g_cos
					assign ni[c] = {3'b000, ONE_Q30 - h_s, 30'd0};
				end
				assign ri[c] = '0;
			end else begin : g_next
				assign ni[c] = rt_n_s[i-1][c];
				assign ri[c] = rt_r_s[i-1][c];
			end
			assign t = ri[c] + BIT;
			always_ff @(posedge clk) begin
				if (en) begin
					if (ni[c] >= t) begin
						rt_n_s[i][c] <= ni[c] - t;
						rt_r_s[i][c] <= (ri[c] >> 1) + BIT;
					end else begin
						rt_n_s[i][c] <= ni[c];
						rt_r_s[i][c] <= ri[c] >> 1;
					end
				end
			end
		end
	end

	// vectoring cordic for atan2(sqrt(h), sqrt(1-h))
	logic signed [33:0] vec_x_s [N];
	logic signed [33:0] vec_y_s [N];
	logic signed [32:0] vec_z_s [N];

	for (genvar j = 0; j < N; j++) begin : g_vec
		logic signed [33:0] xi, yi;
		logic signed [32:0] zi;
		if (j == 0) begin : g_first
			assign xi = signed'({3'b000, rt_r_s[ROOT_STEPS-1][1][30:0]});
			assign yi = signed'({3'b000, rt_r_s[ROOT_STEPS-1][0][30:0]});
			assign zi = '0;
		end else begin : g_next
			assign xi = vec_x_s[j-1];
			assign yi = vec_y_s[j-1];
			assign zi = vec_z_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[33]) begin
					vec_x_s[j] <= xi + (yi >>> j);
					vec_y_s[j] <= yi - (xi >>> j);
					vec_z_s[j] <= zi + signed'(33'(ATAN_Q30[j]));
				end else begin
					vec_x_s[j] <= xi - (yi >>> j);
					vec_y_s[j] <= yi + (xi >>> j);
					vec_z_s[j] <= zi - signed'(33'(ATAN_Q30[j]));
				end
			end
		end
	end

	// scale by the radius
	logic [30:0] zc;
	logic [46:0] prod_s;

	always_comb begin
		if (vec_z_s[N-1] < 0) begin
			zc = '0;
		end else if (vec_z_s[N-1] > 33'(HALF_PI_Q30)) begin
			zc = HALF_PI_Q30;
		end else begin
			zc = vec_z_s[N-1][30:0];
		end
		res_dat = dist_t'(({prod_s, 1'b0} + 48'(1 << 15)) >> 16);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s <= 47'(radius_q) * 47'(zc);
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (out_vld_q && !m_tready) begin
				skid_vld_q <= vld_s[L-1];
			end else begin
				out_vld_q <= vld_s[L-1];
			end
		end else if (m_tready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_vld_q && !m_tready) begin
				skid_dat_q <= res_dat;
			end else begin
				out_dat_q <= res_dat;
			end
		end else if (m_tready) begin
			out_dat_q <= skid_dat_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_dat_q;

	logic unused_root;
	assign unused_root = ^{vld_s[IDX_SQ], vld_s[IDX_ROOT], rt_r_s[ROOT_STEPS-1][0][63:31],
		rt_r_s[ROOT_STEPS-1][1][63:31], rt_n_s[ROOT_STEPS-1][0], rt_n_s[ROOT_STEPS-1][1],
		vec_x_s[N-1], vec_y_s[N-1], s_tdata[127:122]};

endmodule

### design/hav_checker.sv
// checker: port-level assertions for the haversine distance block
`timescale 1ns / 1ps
module hav_checker
	import hav_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m item dropped while stalled");

	a_m_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("m item changed while stalled");

	// back pressure only while a result waits
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input blocked with no result pending");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input blocked without an output stall");

endmodule

bind haversine_distance hav_checker u_hav_checker (.*);

### tb/haversine_distance_tb.sv
// testbench: random and directed point pairs checked against a bit-exact distance predictor
`timescale 1ns / 1ps
module haversine_distance_tb;
	import hav_pkg::*;

	localparam longint LAT90 = 377487360;
	localparam longint LON180 = 754974720;
	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int LATENCY = 2 * STAGES + 40;
	localparam int STALL_LIMIT = 20000;

	class dist_scoreboard;
		dist_t pending[$];
		logic [15:0] radius;
		int errors;

		function new();
			radius = RADIUS_RESET;
			errors = 0;
		endfunction

		// sine and cosine of a signed q23 degree angle, q30 results
		function automatic void sin_cos(input longint a, output longint s, output longint c);
			bit sneg, cneg;
			longint m, x, y, z, xs, ys;
			sneg = a < 0;
			cneg = 0;
			m = sneg ? -a : a;
			m = m % (longint'(360) <<< 23);
			if (m >= (longint'(180) <<< 23)) begin
				m = (longint'(360) <<< 23) - m;
				sneg = !sneg;
			end
			if (m > (longint'(90) <<< 23)) begin
				m = (longint'(180) <<< 23) - m;
				cneg = 1;
			end
			z = (m * longint'(DEG_TO_RAD_Q32) + (longint'(1) <<< 24)) >>> 25;
			x = longint'(CORDIC_GAIN_Q30);
			y = 0;
			for (int i = 0; i < STAGES; i++) begin
				xs = x >>> (i & 31);
				ys = y >>> (i & 31);
				if (z >= 0) begin
					x = x - ys; y = y + xs; z = z - longint'(ATAN_Q30[i & 31]);
				end else begin
					x = x + ys; y = y - xs; z = z + longint'(ATAN_Q30[i & 31]);
				end
			end
			if (x < 0) x = 0;
			if (x > longint'(ONE_Q30)) x = longint'(ONE_Q30);
			if (y < 0) y = 0;
			if (y > longint'(ONE_Q30)) y = longint'(ONE_Q30);
			s = sneg ? -y : y;
			c = cneg ? -x : x;
		endfunction

		function automatic longint unsigned int_root(input longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			for (int i = 0; i < 32; i++) begin
				if (n >= res + b) begin
					n = n - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function automatic dist_t arc_length(input longint la, lo, lb, lob);
			longint s1, s2, ca, cb, unused, s1sq, s2sq, cc, h, x, y, z, xs, ys;
			longint unsigned d;
			sin_cos(lb - la, s1, unused);
			sin_cos(lob - lo, s2, unused);
			sin_cos(la * 2, unused, ca);
			sin_cos(lb * 2, unused, cb);
			s1sq = (s1 * s1) >>> 30;
			s2sq = (s2 * s2) >>> 30;
			cc = (ca * cb) >>> 30;
			h = s1sq + ((cc * s2sq) >>> 30);
			if (h < 0) h = 0;
			if (h > longint'(ONE_Q30)) h = longint'(ONE_Q30);
			y = longint'(int_root(longint'(h) <<< 30));
			x = longint'(int_root((longint'(ONE_Q30) - h) <<< 30));
			z = 0;
			for (int i = 0; i < STAGES; i++) begin
				xs = x >>> (i & 31);
				ys = y >>> (i & 31);
				if (y >= 0) begin
					x = x + ys; y = y - xs; z = z + longint'(ATAN_Q30[i & 31]);
				end else begin
					x = x - ys; y = y + xs; z = z - longint'(ATAN_Q30[i & 31]);
				end
			end
			if (z < 0) z = 0;
			if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
			d = (64'd2 * radius * longint'(z) + (64'd1 << 15)) >> 16;
			return d[31:0];
		endfunction

		function void note_pair(input logic [127:0] data);
			logic signed [29:0] la, lb;
			logic signed [30:0] lo, lob;
			la = data[29:0];
			lo = data[60:30];
			lb = data[90:61];
			lob = data[121:91];
			pending.push_back(arc_length(la, lo, lb, lob));
		endfunction

		function void check_distance(input dist_t got);
			dist_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected distance %0d", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: arc_distance expected %0d actual %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// lat_a, lon_a, lat_b, lon_b, zero fill
	logic [S_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	// arc_distance
	logic [M_TDATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [RADIUS_W-1:0] cfg_wdata;

	dist_scoreboard sb;
	bit hold_req;
	int idle_cycles = 0;

	haversine_distance u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_distance(m_tdata);
	end

	// watchdog on cycles without any item moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver stall pattern
	initial begin
		int mode;
		int cnt;
		mode = 0;
		cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
			end else begin
				if (cnt == 0) begin
					mode = $urandom_range(0, 3);
					cnt = $urandom_range(20, 120);
				end
				cnt--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= $urandom_range(0, 1);
				endcase
			end
		end
	end

	// s_tready only moves at the rising edge, so it is settled here
	task automatic push_pair(input longint la, lo, lb, lob);
		logic [127:0] d;
		d = '0;
		d[29:0] = la[29:0];
		d[60:30] = lo[30:0];
		d[90:61] = lb[29:0];
		d[121:91] = lob[30:0];
		s_tvalid <= 1'b1;
		s_tdata <= d;
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		sb.note_pair(d);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic set_radius(input logic [15:0] r);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.radius = r;
		@(negedge clk);
	endtask

	function automatic longint pick(input longint lim, input int w);
		longint v;
		case ($urandom_range(0, 9))
			0: v = lim;
			1: v = -lim;
			2: v = 0;
			3: v = longint'($signed($urandom)) >>> (32 - w);
			default: v = longint'($urandom_range(0, 2 * lim)) - lim;
		endcase
		return v;
	endfunction

	task automatic random_pair();
		longint la, lo, lb, lob;
		la = pick(LAT90, 30);
		lo = pick(LON180, 31);
		case ($urandom_range(0, 7))
			0: begin
				lb = la; lob = lo;
			end
			1: begin
				lb = -la; lob = (lo > 0) ? lo - LON180 : lo + LON180;
			end
			2: begin
				lb = la + $urandom_range(0, 4000) - 2000;
				lob = lo + $urandom_range(0, 4000) - 2000;
			end
			default: begin
				lb = pick(LAT90, 30);
				lob = pick(LON180, 31);
			end
		endcase
		push_pair(la, lo, lb, lob);
	endtask

	task automatic random_phase(input int n);
		int left;
		left = n;
		while (left > 0) begin
			int burst;
			burst = $urandom_range(1, 40);
			while (burst > 0 && left > 0) begin
				random_pair();
				burst--;
				left--;
			end
			if ($urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 12));
		end
	endtask

	initial begin
		logic [15:0] radii[5];
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_req = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		push_pair(0, 0, 0, 0);
		push_pair(LAT90, LON180, LAT90, LON180);
		push_pair(LAT90, 0, -LAT90, 0);
		push_pair(-LAT90, -LON180, LAT90, LON180);
		push_pair(0, 0, 0, LON180);
		push_pair(0, -LON180, 0, LON180);
		push_pair(0, LON180, 0, -LON180);
		push_pair(LAT90 / 2, LON180 / 3, -LAT90 / 2, -LON180 * 2 / 3);
		push_pair(1, 1, -1, -1);
		push_pair(0, 0, 1, 0);
		push_pair(536870911, 1073741823, -536870912, -1073741824);
		push_pair(-536870912, -1073741824, 536870911, 1073741823);
		push_pair(536870911, 0, 536870911, 0);
		push_pair(LAT90, LON180 / 2, LAT90 - 1, -LON180 / 2);
		push_pair(-LAT90, 12345, -LAT90, -54321);
		push_pair(LAT90 / 3, LON180 / 5, LAT90 / 7, -LON180 / 11);
		push_pair(-LAT90 / 4, LON180 - 1, LAT90 / 4, -LON180 + 1);
		push_pair(300000000, 700000000, -300000000, -54974720);
		drain();

		radii[0] = 16'd1;
		radii[1] = 16'd65535;
		radii[2] = 16'd0;
		radii[3] = $urandom_range(2, 65534);
		radii[4] = RADIUS_RESET;
		for (int p = 0; p < 5; p++) begin
			set_radius(radii[p]);
			if (p == 1) begin
				hold_req = 1;
				for (int i = 0; i < 200; i++)
					random_pair();
			end
			random_phase(170);
			drain();
			random_phase(170);
			drain();
		end

		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
design/hav_pkg.sv
design/haversine_distance.sv
design/hav_checker.sv
tb/haversine_distance_tb.sv
